// ===== hdl/window_function_generator_unit_assert.svh =====
// Assertion macros shared by the window function generator.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef WINDOW_FUNCTION_GENERATOR_UNIT_ASSERT_SVH
`define WINDOW_FUNCTION_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFG_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window generator check failed");

// The consequent must hold after the antecedent, at the delay given by argument n.
`define WFG_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("window generator latency check failed");

`endif

// ===== hdl/wfg_pkg.sv =====
// Package of the window function generator: codes, item types, coefficients.
// Used by every module of the block; depends on nothing.
package wfg_pkg;

    localparam int PHASE_BITS_DEF     = 16;
    localparam int COS_TABLE_BITS_DEF = 10;

    localparam int DIV_STAGES      = 25;
    localparam int COS_CELLS       = 4;
    localparam int COS_CELL_STAGES = 5;

    localparam logic [3:0] KIND_RECT     = 4'd0;
    localparam logic [3:0] KIND_TRI      = 4'd1;
    localparam logic [3:0] KIND_TRAP     = 4'd2;
    localparam logic [3:0] KIND_WELCH    = 4'd3;
    localparam logic [3:0] KIND_SINE     = 4'd4;
    localparam logic [3:0] KIND_HANN     = 4'd5;
    localparam logic [3:0] KIND_HAMMING  = 4'd6;
    localparam logic [3:0] KIND_BLACKMAN = 4'd7;
    localparam logic [3:0] KIND_NUTTALL  = 4'd8;
    localparam logic [3:0] KIND_BLNUTT   = 4'd9;
    localparam logic [3:0] KIND_BLHARRIS = 4'd10;
    localparam logic [3:0] KIND_FLATTOP  = 4'd11;
    localparam logic [3:0] KIND_TUKEY    = 4'd12;

    localparam logic [1:0] CFG_KIND = 2'd0;
    localparam logic [1:0] CFG_A    = 2'd1;
    localparam logic [1:0] CFG_B    = 2'd2;

    localparam logic [2:0] SRC_ZERO  = 3'd0;
    localparam logic [2:0] SRC_ONE   = 3'd1;
    localparam logic [2:0] SRC_QUO   = 3'd2;
    localparam logic [2:0] SRC_WELCH = 3'd3;
    localparam logic [2:0] SRC_COS   = 3'd4;

    localparam logic [24:0] ONE24   = 25'h1000000;
    localparam logic [24:0] QUARTER = 25'h0800000;

    typedef struct packed {
        logic [2:0]  src;
        logic [3:0]  kind;
        logic [23:0] x;
        logic [16:0] welch;
    } div_item_t;

    typedef struct packed {
        logic [2:0]  src;
        logic [3:0]  kind;
        logic [16:0] val;
        logic [63:0] acc;
        logic [24:0] angle;
        logic [24:0] step;
    } cos_item_t;

    localparam logic signed [31:0] SUM_COEF [7][5] = '{
        '{32'sd536870912, 32'sd536870912, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd583555339, 32'sd490186485, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd458048291, 32'sd533177905, 32'sd82515628, 32'sd0, 32'sd0},
        '{32'sd382002981, 32'sd523337470, 32'sd154867931, 32'sd13533442, 32'sd0},
        '{32'sd390393094, 32'sd525250341, 32'sd146672596, 32'sd11425794, 32'sd0},
        '{32'sd385204879, 32'sd524297395, 32'sd151698245, 32'sd12541305, 32'sd0},
        '{32'sd231609333, 32'sd447006012, 32'sd298776039, 32'sd89864421, 32'sd6485061}
    };

    function automatic logic is_sum_kind(logic [3:0] kind);
        return (kind >= KIND_HANN) && (kind <= KIND_FLATTOP);
    endfunction

    function automatic logic signed [31:0] base_coef(logic [3:0] kind);
        logic signed [31:0] c;
        c = 32'sd0;
        if (is_sum_kind(kind)) begin
            c = SUM_COEF[3'(kind - KIND_HANN)][0];
        end else if (kind == KIND_TUKEY) begin
            c = 32'sd536870912;
        end
        return c;
    endfunction

    function automatic logic signed [31:0] cos_coef(logic [3:0] kind, int idx);
        logic signed [31:0] c;
        c = 32'sd0;
        if (is_sum_kind(kind)) begin
            c = SUM_COEF[3'(kind - KIND_HANN)][idx];
            if ((idx & 1) == 1) begin
                c = -c;
            end
        end else if (kind == KIND_SINE) begin
            c = (idx == 1) ? 32'sd1073741824 : 32'sd0;
        end else if (kind == KIND_TUKEY) begin
            c = (idx == 1) ? -32'sd536870912 : 32'sd0;
        end
        return c;
    endfunction

    // Truncating quotient by shift and subtract, used only while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave cosine entry in Q1.30, from a truncated integer Taylor series.
    function automatic logic [30:0] cos_entry(int k, int tb);
        logic [63:0]        th;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic [63:0]        dv;
        logic signed [63:0] sum;
        th   = (64'd1686629713 * 64'(k)) >> tb;
        th2  = (th * th) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            dv   = 64'((2 * n - 1) * (2 * n));
            term = udiv64((term * th2) >> 30, dv);
            if ((n & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > (64'sd1 << 30)) begin
            sum = 64'sd1 << 30;
        end
        return sum[30:0];
    endfunction

endpackage

// ===== hdl/window_function_generator_unit.sv =====
// Top level of the window function generator: registers, divider chain, cosine chain.
// Depends on wfg_pkg, wfg_div_cell, wfg_cos_cell and the assertion macro header.
//
// Channel   Direction  Handshake               Payload
// command   in         start && !busy          phase
// result    out        done, one cycle         window_value, clipped
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// One item is accepted every cycle; busy stays low.
// Each result passes through 25 divider cells, four cosine cells
// of five stages each, and the input, setup and output registers.
// Reset clears the valid chain and loads the register defaults; the cosine table is constant.
// Configuration writes are taken in every cycle; the receiver cannot stall results.
`include "window_function_generator_unit_assert.svh"

module window_function_generator_unit #(
    parameter int PHASE_BITS     = wfg_pkg::PHASE_BITS_DEF,
    parameter int COS_TABLE_BITS = wfg_pkg::COS_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        phase,
    output logic               done,
    output logic signed [17:0] window_value,
    output logic               clipped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int DS  = wfg_pkg::DIV_STAGES;
    localparam int CC  = wfg_pkg::COS_CELLS;
    localparam int LAT = 3 + DS + CC * wfg_pkg::COS_CELL_STAGES;
    localparam logic [23:0] PH_MASK = 24'((64'd1 << PHASE_BITS) - 64'd1);

    logic [3:0]  kind_reg;
    logic [15:0] a_reg;
    logic [15:0] b_reg;

    logic        in_valid_reg;
    logic [23:0] x_reg;

    logic [23:0] a24;
    logic [23:0] b24;
    logic [24:0] nx;
    logic [24:0] na;
    logic [24:0] nb;
    logic [48:0] welch_prod;
    wfg_pkg::div_item_t front_item;
    logic [24:0] front_num;
    logic [24:0] front_den;

    logic               div_valid [0:DS];
    wfg_pkg::div_item_t div_item  [0:DS];
    logic [24:0]        div_rem   [0:DS];
    logic [24:0]        div_den   [0:DS];
    logic [24:0]        div_quo   [0:DS];

    wfg_pkg::cos_item_t setup_item;
    logic               setup_valid_reg;
    wfg_pkg::cos_item_t setup_item_reg;

    logic               cos_valid [0:CC];
    wfg_pkg::cos_item_t cos_item  [0:CC];

    wfg_pkg::cos_item_t last_item;
    logic signed [63:0] rnd;
    logic signed [19:0] v;
    logic signed [19:0] v_sat;
    logic               clip;

    logic               done_reg;
    logic signed [17:0] value_reg;
    logic               clipped_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= wfg_pkg::KIND_BLACKMAN;
            a_reg    <= 16'd32768;
            b_reg    <= 16'd49152;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wfg_pkg::CFG_KIND: kind_reg <= cfg_data[3:0];
                wfg_pkg::CFG_A:    a_reg    <= cfg_data;
                wfg_pkg::CFG_B:    b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            setup_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= start && !busy;
            setup_valid_reg <= div_valid[DS];
            done_reg        <= cos_valid[CC];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= ({8'h00, phase} & PH_MASK) << (24 - PHASE_BITS);
    end

    always_comb
    begin
        a24        = {a_reg, 8'h00};
        b24        = {b_reg, 8'h00};
        nx         = wfg_pkg::ONE24 - {1'b0, x_reg};
        na         = wfg_pkg::ONE24 - {1'b0, a24};
        nb         = wfg_pkg::ONE24 - {1'b0, b24};
        welch_prod = 49'(x_reg) * 49'(nx);

        front_item.kind  = kind_reg;
        front_item.x     = x_reg;
        front_item.welch = 17'((welch_prod + (49'd1 << 29)) >> 30);
        front_item.src   = wfg_pkg::SRC_ZERO;
        front_num        = '0;
        front_den        = 25'd1;

        unique case (kind_reg)
            wfg_pkg::KIND_RECT:
                front_item.src = wfg_pkg::SRC_ONE;
            wfg_pkg::KIND_TRI:
            begin
                front_item.src = wfg_pkg::SRC_QUO;
                if (x_reg < a24)
                begin
                    front_num = {1'b0, x_reg};
                    front_den = {1'b0, a24};
                end
                else
                begin
                    front_num = nx;
                    front_den = na;
                end
            end
            wfg_pkg::KIND_TRAP:
            begin
                priority if (x_reg < a24)
                begin
                    front_item.src = wfg_pkg::SRC_QUO;
                    front_num      = {1'b0, x_reg};
                    front_den      = {1'b0, a24};
                end
                else if (x_reg < b24)
                begin
                    front_item.src = wfg_pkg::SRC_ONE;
                end
                else
                begin
                    front_item.src = wfg_pkg::SRC_QUO;
                    front_num      = nx;
                    front_den      = nb;
                end
            end
            wfg_pkg::KIND_WELCH:
                front_item.src = wfg_pkg::SRC_WELCH;
            wfg_pkg::KIND_SINE, wfg_pkg::KIND_HANN, wfg_pkg::KIND_HAMMING,
            wfg_pkg::KIND_BLACKMAN, wfg_pkg::KIND_NUTTALL, wfg_pkg::KIND_BLNUTT,
            wfg_pkg::KIND_BLHARRIS, wfg_pkg::KIND_FLATTOP:
                front_item.src = wfg_pkg::SRC_COS;
            wfg_pkg::KIND_TUKEY:
            begin
                priority if (x_reg < a24)
                begin
                    front_item.src = wfg_pkg::SRC_COS;
                    front_num      = {1'b0, x_reg};
                    front_den      = {1'b0, a24};
                end
                else if (({1'b0, x_reg} < na) || (a_reg == 16'd0))
                begin
                    front_item.src = wfg_pkg::SRC_ONE;
                end
                else
                begin
                    front_item.src = wfg_pkg::SRC_COS;
                    front_num      = nx;
                    front_den      = {1'b0, a24};
                end
            end
            default:
                front_item.src = wfg_pkg::SRC_ZERO;
        endcase
    end

    assign div_valid[0] = in_valid_reg;
    assign div_item[0]  = front_item;
    assign div_rem[0]   = front_num;
    assign div_den[0]   = front_den;
    assign div_quo[0]   = '0;

    for (genvar j = 0; j < DS; j++)
    begin : g_div
        wfg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[j]),
            .in_item   (div_item[j]),
            .in_rem    (div_rem[j]),
            .in_den    (div_den[j]),
            .in_quo    (div_quo[j]),
            .out_valid (div_valid[j+1]),
            .out_item  (div_item[j+1]),
            .out_rem   (div_rem[j+1]),
            .out_den   (div_den[j+1]),
            .out_quo   (div_quo[j+1])
        );
    end

    always_comb
    begin
        setup_item.src  = div_item[DS].src;
        setup_item.kind = div_item[DS].kind;
        setup_item.val  = (div_item[DS].src == wfg_pkg::SRC_QUO) ? div_quo[DS][24:8]
                                                                 : div_item[DS].welch;
        setup_item.acc  = 64'($signed(wfg_pkg::base_coef(div_item[DS].kind))) << 30;
        setup_item.step = {div_item[DS].x, 1'b0};
        if (div_item[DS].kind == wfg_pkg::KIND_TUKEY)
        begin
            setup_item.angle = div_quo[DS];
        end
        else if (div_item[DS].kind == wfg_pkg::KIND_SINE)
        begin
            setup_item.angle = {1'b0, div_item[DS].x} - wfg_pkg::QUARTER;
        end
        else
        begin
            setup_item.angle = {div_item[DS].x, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        setup_item_reg <= setup_item;
    end

    assign cos_valid[0] = setup_valid_reg;
    assign cos_item[0]  = setup_item_reg;

    for (genvar m = 0; m < CC; m++)
    begin : g_cos
        wfg_cos_cell #(
            .COS_TABLE_BITS (COS_TABLE_BITS),
            .CELL_IDX       (m + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cos_valid[m]),
            .in_item   (cos_item[m]),
            .out_valid (cos_valid[m+1]),
            .out_item  (cos_item[m+1])
        );
    end

    always_comb
    begin
        last_item = cos_item[CC];
        rnd       = $signed(last_item.acc) + (64'sd1 <<< 43);
        unique case (last_item.src)
            wfg_pkg::SRC_ONE:                    v = 20'sd65536;
            wfg_pkg::SRC_QUO, wfg_pkg::SRC_WELCH: v = $signed({3'b000, last_item.val});
            wfg_pkg::SRC_COS:                    v = rnd[63:44];
            default:                             v = 20'sd0;
        endcase
        clip  = 1'b0;
        v_sat = v;
        if (v > 20'sd65536)
        begin
            v_sat = 20'sd65536;
            clip  = 1'b1;
        end
        else if (v < -20'sd65536)
        begin
            v_sat = -20'sd65536;
            clip  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= 18'(v_sat);
        clipped_reg <= clip;
    end

    assign done         = done_reg;
    assign window_value = value_reg;
    assign clipped      = clipped_reg;

    `WFG_ASSERT_DELAY(a_latency, start && !busy, LAT, done)
    `WFG_ASSERT_IMPLY(a_clip_value, done && clipped, (window_value == 18'sd65536) || (window_value == -18'sd65536))
    `WFG_ASSERT_IMPLY(a_range, done, (window_value <= 18'sd65536) && (window_value >= -18'sd65536))

endmodule

// ===== hdl/wfg_div_cell.sv =====
// One cell of the pipelined restoring divider: yields one quotient bit per item.
// Depends on wfg_pkg for the item type carried alongside.
module wfg_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  wfg_pkg::div_item_t  in_item,
    input  logic [24:0]         in_rem,
    input  logic [24:0]         in_den,
    input  logic [24:0]         in_quo,
    output logic                out_valid,
    output wfg_pkg::div_item_t  out_item,
    output logic [24:0]         out_rem,
    output logic [24:0]         out_den,
    output logic [24:0]         out_quo
);

    logic [25:0] diff;
    logic        ge;
    logic [24:0] rem_n;

    logic               valid_reg;
    wfg_pkg::div_item_t item_reg;
    logic [24:0]        rem_reg;
    logic [24:0]        den_reg;
    logic [24:0]        quo_reg;

    always_comb
    begin
        diff  = {1'b0, in_rem} - {1'b0, in_den};
        ge    = !diff[25];
        rem_n = ge ? diff[24:0] : in_rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= in_item;
        rem_reg  <= {rem_n[23:0], 1'b0};
        den_reg  <= in_den;
        quo_reg  <= {in_quo[23:0], ge};
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;

endmodule

// ===== hdl/wfg_cos_cell.sv =====
// One cell of the cosine-sum chain: interpolated cosine, coefficient product, accumulate.
// Depends on wfg_pkg for the item type, coefficients and the table entries.
module wfg_cos_cell #(
    parameter int COS_TABLE_BITS = wfg_pkg::COS_TABLE_BITS_DEF,
    parameter int CELL_IDX       = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  wfg_pkg::cos_item_t in_item,
    output logic               out_valid,
    output wfg_pkg::cos_item_t out_item
);

    localparam int TAB_N = 1 << COS_TABLE_BITS;
    localparam int SH    = 23 - COS_TABLE_BITS;
    localparam int IW    = COS_TABLE_BITS + 1;
    localparam int PW    = 33 + SH;

    typedef logic [30:0] rom_t [0:TAB_N];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= TAB_N; k++) begin
            r[k] = wfg_pkg::cos_entry(k, COS_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic [1:0]  quad;
    logic [23:0] rr;
    logic [IW-1:0] idx0;
    logic [IW-1:0] idx1;
    logic signed [31:0] delta;
    logic signed [31:0] cosv;
    wfg_pkg::cos_item_t out_next;

    logic [4:0]          valid_reg;
    wfg_pkg::cos_item_t  item1_reg;
    wfg_pkg::cos_item_t  item2_reg;
    wfg_pkg::cos_item_t  item3_reg;
    wfg_pkg::cos_item_t  item4_reg;
    wfg_pkg::cos_item_t  out_reg;
    logic [30:0]         tab0_reg;
    logic [30:0]         tab1_reg;
    logic [30:0]         tab0b_reg;
    logic [SH-1:0]       frac_reg;
    logic [1:0]          neg_reg;
    logic signed [31:0]  coef1_reg;
    logic signed [31:0]  coef2_reg;
    logic signed [31:0]  coef3_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0]  cos_reg;
    logic signed [63:0]  term_reg;

    always_comb
    begin
        quad  = in_item.angle[24:23];
        rr    = quad[0] ? (24'h800000 - {1'b0, in_item.angle[22:0]})
                        : {1'b0, in_item.angle[22:0]};
        idx0  = rr[23:SH];
        idx1  = (idx0 == IW'(TAB_N)) ? idx0 : idx0 + 1'b1;
        delta = $signed({1'b0, tab1_reg}) - $signed({1'b0, tab0_reg});
        cosv  = $signed({1'b0, tab0b_reg}) + 32'(prod_reg >>> SH);

        out_next       = item4_reg;
        out_next.acc   = 64'($signed(item4_reg.acc) + term_reg);
        out_next.angle = item4_reg.angle + item4_reg.step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= in_item;
        tab0_reg  <= COS_ROM[idx0];
        tab1_reg  <= COS_ROM[idx1];
        frac_reg  <= rr[SH-1:0];
        neg_reg   <= {neg_reg[0], quad[1] ^ quad[0]};
        coef1_reg <= wfg_pkg::cos_coef(in_item.kind, CELL_IDX);

        item2_reg  <= item1_reg;
        tab0b_reg  <= tab0_reg;
        coef2_reg  <= coef1_reg;
        prod_reg   <= delta * $signed({1'b0, frac_reg});

        item3_reg  <= item2_reg;
        coef3_reg  <= coef2_reg;
        cos_reg    <= neg_reg[1] ? -cosv : cosv;

        item4_reg <= item3_reg;
        term_reg  <= coef3_reg * cos_reg;

        out_reg <= out_next;
    end

    assign out_valid = valid_reg[4];
    assign out_item  = out_reg;

endmodule
